@@ src/square_matrix_rotate_cw_defines.svh @@
// Assertion macros shared by the matrix rotate block.
// Included by the controller and the datapath; depends on nothing else.
`ifndef SQUARE_MATRIX_ROTATE_CW_DEFINES_SVH
`define SQUARE_MATRIX_ROTATE_CW_DEFINES_SVH

// Same-cycle implication.
`define SMRC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SMRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/smrc_pkg.sv @@
// Shared types and constants of the matrix rotate block.
// Used by the controller, the datapath and the top level; depends on nothing.
package smrc_pkg;

   localparam int VALUE_BITS = 16;
   localparam int CFG_BITS   = 6;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_FETCH = 1'b1;

   typedef struct packed {
      logic load;
      logic read;
      logic reject;
      logic capture;
   } ctl_cmd_type;

   typedef struct packed {
      logic frame_full;
   } dp_status_type;

endpackage

@@ src/smrc_ram.sv @@
// Generic single-port RAM with registered read data.
// Used for the frame store; depends on nothing.
module smrc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wr_data,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/smrc_ctrl.sv @@
// Handshake controller of the matrix rotate block: accepts words, issues
// datapath commands and owns the result valid. Depends on smrc_pkg and the defines header.
`include "square_matrix_rotate_cw_defines.svh"

module smrc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_action,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  smrc_pkg::dp_status_type status,
   output smrc_pkg::ctl_cmd_type  cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE) && (!valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = valid_ff;

   always_comb begin
      cmd.load    = accept && (req_action == smrc_pkg::ACT_LOAD);
      cmd.read    = accept && (req_action == smrc_pkg::ACT_FETCH) && status.frame_full;
      cmd.reject  = accept && (req_action == smrc_pkg::ACT_FETCH) && !status.frame_full;
      cmd.capture = (state_ff == ST_READ);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.read) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      valid_in = valid_ff;
      if (cmd.capture || cmd.reject) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   `SMRC_ASSERT_NEXT(a_read_then_capture, clock, reset, cmd.read, cmd.capture, "read not followed by capture")
   `SMRC_ASSERT_NEXT(a_capture_sets_valid, clock, reset, cmd.capture || cmd.reject, valid_ff, "result lost")
   `SMRC_ASSERT_NOW(a_no_accept_when_blocked, clock, reset, valid_ff && !rsp_tready, !req_tready, "accept while result stalled")

endmodule

@@ src/smrc_dpath.sv @@
// Datapath of the matrix rotate block: side register, load and readout
// counters, frame store and result register. Depends on smrc_pkg, smrc_ram, defines header.
`include "square_matrix_rotate_cw_defines.svh"

module smrc_dpath #(
   parameter int MAX_SIDE   = 32,
   parameter int PIXEL_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  smrc_pkg::ctl_cmd_type                 cmd,
   output smrc_pkg::dp_status_type               status,
   input  logic                                  csr_wr_en,
   input  logic [smrc_pkg::CFG_BITS-1:0]         csr_wr_data,
   input  logic [smrc_pkg::VALUE_BITS-1:0]       req_pixel,
   output logic [smrc_pkg::VALUE_BITS-1:0]       rsp_value,
   output logic                                  rsp_last,
   output logic                                  rsp_err
);

   localparam int IDX_W   = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int DEPTH   = MAX_SIDE * MAX_SIDE;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int STORE_W = (PIXEL_BITS < smrc_pkg::VALUE_BITS) ? PIXEL_BITS
                                                               : smrc_pkg::VALUE_BITS;
   localparam int CMP_W   = ($clog2(MAX_SIDE + 1) > smrc_pkg::CFG_BITS) ?
                            $clog2(MAX_SIDE + 1) : smrc_pkg::CFG_BITS;
   localparam int RESET_SIZE = ((MAX_SIDE % 64) != 0) ? (MAX_SIDE % 64) : MAX_SIDE;
   localparam logic [IDX_W-1:0] RESET_LAST = IDX_W'(RESET_SIZE - 1);

   logic [IDX_W-1:0] side_last_ff, side_last_in;
   logic [IDX_W-1:0] load_row_ff, load_row_in;
   logic [IDX_W-1:0] load_col_ff, load_col_in;
   logic [IDX_W-1:0] out_row_ff, out_row_in;
   logic [IDX_W-1:0] out_col_ff, out_col_in;
   logic             frame_full_ff, frame_full_in;
   logic             last_pend_ff;

   logic [smrc_pkg::VALUE_BITS-1:0] value_ff, value_in;
   logic                            last_ff, last_in;
   logic                            err_ff, err_in;

   logic [CMP_W-1:0]  cfg_n;
   logic [IDX_W-1:0]  lr, lc, src_row;
   logic [ADDR_W-1:0] wr_addr, rd_addr, ram_addr;
   logic [STORE_W-1:0] rd_data;

   assign status.frame_full = frame_full_ff;

   // new frame starts at the origin once the previous one is complete
   assign lr      = frame_full_ff ? '0 : load_row_ff;
   assign lc      = frame_full_ff ? '0 : load_col_ff;
   assign src_row = side_last_ff - out_col_ff;
   assign wr_addr = ADDR_W'(lr) * ADDR_W'(MAX_SIDE) + ADDR_W'(lc);
   assign rd_addr = ADDR_W'(src_row) * ADDR_W'(MAX_SIDE) + ADDR_W'(out_row_ff);
   assign ram_addr = cmd.load ? wr_addr : rd_addr;

   always_comb begin
      cfg_n = CMP_W'(csr_wr_data);
      if (cfg_n == '0) begin
         cfg_n = CMP_W'(1);
      end else if (cfg_n > CMP_W'(MAX_SIDE)) begin
         cfg_n = CMP_W'(MAX_SIDE);
      end
   end

   always_comb begin
      side_last_in  = side_last_ff;
      load_row_in   = load_row_ff;
      load_col_in   = load_col_ff;
      out_row_in    = out_row_ff;
      out_col_in    = out_col_ff;
      frame_full_in = frame_full_ff;
      if (csr_wr_en) begin
         side_last_in  = IDX_W'(cfg_n - CMP_W'(1));
         load_row_in   = '0;
         load_col_in   = '0;
         out_row_in    = '0;
         out_col_in    = '0;
         frame_full_in = 1'b0;
      end else if (cmd.load) begin
         if (frame_full_ff) begin
            out_row_in    = '0;
            out_col_in    = '0;
            frame_full_in = 1'b0;
         end
         if (lc == side_last_ff) begin
            load_col_in = '0;
            if (lr == side_last_ff) begin
               load_row_in   = '0;
               frame_full_in = 1'b1;
               out_row_in    = '0;
               out_col_in    = '0;
            end else begin
               load_row_in = lr + IDX_W'(1);
            end
         end else begin
            load_row_in = lr;
            load_col_in = lc + IDX_W'(1);
         end
      end else if (cmd.read) begin
         if (out_col_ff == side_last_ff) begin
            out_col_in = '0;
            if (out_row_ff == side_last_ff) begin
               out_row_in = '0;
            end else begin
               out_row_in = out_row_ff + IDX_W'(1);
            end
         end else begin
            out_col_in = out_col_ff + IDX_W'(1);
         end
      end
   end

   always_comb begin
      value_in = value_ff;
      last_in  = last_ff;
      err_in   = err_ff;
      if (cmd.capture) begin
         value_in = smrc_pkg::VALUE_BITS'(signed'(rd_data));
         last_in  = last_pend_ff;
         err_in   = 1'b0;
      end else if (cmd.reject) begin
         value_in = '0;
         last_in  = 1'b0;
         err_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_last_ff  <= RESET_LAST;
         load_row_ff   <= '0;
         load_col_ff   <= '0;
         out_row_ff    <= '0;
         out_col_ff    <= '0;
         frame_full_ff <= 1'b0;
      end else begin
         side_last_ff  <= side_last_in;
         load_row_ff   <= load_row_in;
         load_col_ff   <= load_col_in;
         out_row_ff    <= out_row_in;
         out_col_ff    <= out_col_in;
         frame_full_ff <= frame_full_in;
      end
   end

   always_ff @(posedge clock) begin
      last_pend_ff <= (out_row_ff == side_last_ff) && (out_col_ff == side_last_ff);
      value_ff     <= value_in;
      last_ff      <= last_in;
      err_ff       <= err_in;
   end

   smrc_ram #(
      .WIDTH (STORE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.load),
      .addr    (ram_addr),
      .wr_data (req_pixel[STORE_W-1:0]),
      .rd_data (rd_data)
   );

   assign rsp_value = value_ff;
   assign rsp_last  = last_ff;
   assign rsp_err   = err_ff;

   `SMRC_ASSERT_NOW(a_read_needs_full, clock, reset, cmd.read, frame_full_ff, "read of incomplete frame")
   `SMRC_ASSERT_NEXT(a_reject_flags_err, clock, reset, cmd.reject, err_ff && !last_ff, "reject not flagged")

endmodule

@@ src/square_matrix_rotate_cw.sv @@
// Top level of the matrix rotate block: 90-degree clockwise rotating frame buffer.
// Depends on smrc_pkg, smrc_ctrl, smrc_dpath and smrc_ram.
//
// Load words (req_tuser 0) fill an n x n frame in row-major order; fetch words
// (req_tuser 1) return the frame rotated clockwise, row-major, with rsp_tlast on
// the final element and rsp_tuser set when the frame is not yet complete (data 0).
// A fetch of a complete frame goes through the registered read of the single-port
// frame store and then the result register, holding off other words until it is
// captured; a fetch before the frame is complete goes straight to the result
// register. Loads produce no response word. A response word left waiting in the
// output register holds off every load and fetch until it is taken.
// Writing csr_wr_data sets n (0 acts as 1, values above MAX_SIDE as MAX_SIDE) and
// discards the current frame; write it only while the block is idle.
module square_matrix_rotate_cw #(
   parameter int MAX_SIDE   = 32,
   parameter int PIXEL_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [smrc_pkg::CFG_BITS-1:0]     csr_wr_data,  // size_in_use
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [smrc_pkg::VALUE_BITS-1:0]   req_tdata,    // [15:0] pixel_value
   input  logic                              req_tuser,    // [0] action
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [smrc_pkg::VALUE_BITS-1:0]   rsp_tdata,    // [15:0] rotated_value
   output logic                              rsp_tlast,    // frame_last
   output logic                              rsp_tuser     // [0] not_ready
);

   smrc_pkg::ctl_cmd_type   cmd;
   smrc_pkg::dp_status_type status;

   smrc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_action (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   smrc_dpath #(
      .MAX_SIDE   (MAX_SIDE),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_pixel   (req_tdata),
      .rsp_value   (rsp_tdata),
      .rsp_last    (rsp_tlast),
      .rsp_err     (rsp_tuser)
   );

endmodule
